/* src/fpwd_pkg.sv */
// Shared types and constants for the frame pacer.
`timescale 1ns / 1ps

package fpwd_pkg;

	localparam int WAIT_W    = 32;
	localparam int STAMP_W   = 48;
	localparam int SEQ_W     = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_LATE    = 2'd1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_now;
		logic start_tick;
		logic cmp;
		logic div_step;
		logic fin;
		logic skip;
		logic adv;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic started;
		logic early;
		logic period_zero;
		logic drop;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

/* src/fpwd_ctrl.sv */
// Sequencing controller of the frame pacer.
`timescale 1ns / 1ps

module fpwd_ctrl
	import fpwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_CMP,
		S_DIV,
		S_FIN,
		S_SKIP,
		S_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_START;
				S_START: state_q <= S_CMP;
				S_CMP: begin
					if (sts.early || sts.period_zero) state_q <= S_OUT;
					else state_q <= S_DIV;
				end
				S_DIV:   if (sts.div_last) state_q <= S_FIN;
				S_FIN:   state_q <= sts.drop ? S_SKIP : S_OUT;
				S_SKIP:  state_q <= S_OUT;
				S_OUT:   if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.load_now   = (state_q == S_IDLE) && in_valid;
		cmd.start_tick = (state_q == S_START);
		cmd.cmp        = (state_q == S_CMP);
		cmd.div_step   = (state_q == S_DIV);
		cmd.fin        = (state_q == S_FIN);
		cmd.skip       = (state_q == S_SKIP);
		cmd.adv        = (state_q == S_OUT) && sts.out_free;
	end

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |=> state_q == S_DIV || state_q == S_FIN)
		else $error("divider left by an unexpected path");

	a_cmp_started: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> sts.started)
		else $error("compare before a tick was scheduled");

	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv |=> state_q == S_IDLE)
		else $error("controller did not return after output");

endmodule

/* src/fpwd_dp.sv */
// Datapath of the frame pacer: tick, sequence, divider and output word.
`timescale 1ns / 1ps

module fpwd_dp
	import fpwd_pkg::*;
#(
	parameter int TIME_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic [STAMP_W-1:0]   now_time,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [WAIT_W-1:0]    wait_ticks,
	output logic [STAMP_W-1:0]   release_time,
	output logic [SEQ_W-1:0]     frame_seq
);

	localparam int WIDE_W = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;
	localparam int CNT_W  = $clog2(TIME_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_BITS - 1);

	logic [WAIT_W-1:0]    period_q;
	logic                 drop_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] next_q;
	logic                 started_q;
	logic [SEQ_W-1:0]     seq_q;
	logic [WAIT_W-1:0]    wait_q;
	logic [TIME_BITS-1:0] quot_q;
	logic [WAIT_W:0]      rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic [WAIT_W-1:0]    wait_out_q;
	logic [STAMP_W-1:0]   release_q;
	logic [SEQ_W-1:0]     seq_out_q;

	logic [WIDE_W-1:0]    now_wide;
	logic [TIME_BITS-1:0] period_t;
	logic [TIME_BITS-1:0] ahead;
	logic                 early;
	logic [WAIT_W-1:0]    ahead_sat;
	logic [WAIT_W:0]      rem_sh;
	logic                 rem_ge;
	logic [TIME_BITS-1:0] rel_t;
	logic [WIDE_W-1:0]    rel_wide;
	logic [WIDE_W-1:0]    miss_wide;
	logic                 out_free;

	assign now_wide  = WIDE_W'(now_time);
	assign period_t  = TIME_BITS'(period_q);
	assign ahead     = next_q - now_q;
	assign early     = (ahead != '0) && !ahead[TIME_BITS-1];
	assign ahead_sat = ((ahead >> WAIT_W) != '0) ? '1 : ahead[WAIT_W-1:0];
	assign rem_sh    = {rem_q[WAIT_W-1:0], quot_q[TIME_BITS-1]};
	assign rem_ge    = rem_sh >= {1'b0, period_q};
	assign rel_t     = now_q + TIME_BITS'(wait_q);
	assign rel_wide  = WIDE_W'(rel_t);
	assign miss_wide = WIDE_W'(quot_q);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		sts             = '0;
		sts.started     = started_q;
		sts.early       = early;
		sts.period_zero = (period_q == '0);
		sts.drop        = drop_q;
		sts.div_last    = (cnt_q == CNT_LAST);
		sts.out_free    = out_free;
	end

	// Registers and pacing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= '0;
			drop_q    <= 1'b0;
			next_q    <= '0;
			started_q <= 1'b0;
			seq_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_PERIOD: period_q <= cfg_data;
					REG_DROP_LATE:    drop_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.start_tick && !started_q) begin
				next_q    <= now_q + period_t;
				started_q <= 1'b1;
			end
			if (cmd.fin) begin
				// last tick at or before now
				next_q <= now_q - TIME_BITS'(rem_q[WAIT_W-1:0]);
			end
			if (cmd.skip) begin
				next_q <= next_q + period_t;
				seq_q  <= seq_q + miss_wide[SEQ_W-1:0] + SEQ_W'(1);
			end
			if (cmd.adv) begin
				next_q <= next_q + period_t;
				seq_q  <= seq_q + SEQ_W'(1);
			end
		end
	end

	// Request, wait and divider working registers
	always_ff @(posedge clk) begin
		if (cmd.load_now) now_q <= now_wide[TIME_BITS-1:0];
		if (cmd.cmp) begin
			wait_q <= early ? ahead_sat : '0;
			quot_q <= now_q - next_q;
			rem_q  <= '0;
			cnt_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_ge ? (rem_sh - {1'b0, period_q}) : rem_sh;
			quot_q <= {quot_q[TIME_BITS-2:0], rem_ge};
			cnt_q  <= cnt_q + CNT_W'(1);
		end
		if (cmd.fin && drop_q) wait_q <= period_q - rem_q[WAIT_W-1:0];
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv) begin
			wait_out_q <= wait_q;
			release_q  <= rel_wide[STAMP_W-1:0];
			seq_out_q  <= seq_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign wait_ticks   = wait_out_q;
	assign release_time = release_q;
	assign frame_seq    = seq_out_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> rem_q < {1'b0, period_q})
		else $error("divider remainder not below period");

	a_drop_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && drop_q |=> wait_q != '0)
		else $error("dropped frame given zero wait");

	a_adv_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv |=> out_valid_q)
		else $error("output word not presented after load");

endmodule

/* src/frame_pacer_with_drop.sv */
// Frame pacer top level: config port, controller and datapath.
//
// Each request word on the input channel (in_valid, in_stall) carries
// now_time. The block answers with one word on the output channel
// (out_valid, out_stall): wait_ticks, release_time = now + wait, and
// frame_seq. The first request schedules a tick one frame_period ahead;
// early requests wait for it, late ones go out at once or, with
// drop_late_frames set, skip missed ticks and wait for the next one.
// After acceptance, an early request or a zero period passes the start
// and compare states and goes to output; a late one first runs the
// bit-serial restoring divider that finds the missed ticks (one quotient
// bit a cycle), then a finish state and, in drop mode, a skip state.
// One request is in work at a time, so the next is taken once the result
// is in the output register. The output register holds its word while
// out_stall is high; a new request may be taken meanwhile but its result
// waits until the register frees. Reset clears the schedule, the sequence
// counter and both config registers. Config writes (cfg_valid, cfg_ready)
// are always taken and must happen only while the block is idle.
`timescale 1ns / 1ps

module frame_pacer_with_drop
	import fpwd_pkg::*;
#(
	parameter int TIME_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [STAMP_W-1:0]   now_time,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WAIT_W-1:0]    wait_ticks,
	output logic [STAMP_W-1:0]   release_time,
	output logic [SEQ_W-1:0]     frame_seq
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	fpwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fpwd_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.now_time     (now_time),
		.cmd          (cmd),
		.sts          (sts),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.wait_ticks   (wait_ticks),
		.release_time (release_time),
		.frame_seq    (frame_seq)
	);

endmodule
